// ----- src/fpa_pkg.sv -----
// shared types, constants and codes of the fit-policy partition allocator
`default_nettype none
package fpa_pkg;

    localparam int PARTITIONS = 8;
    localparam int TASK_SLOTS = 1024;

    localparam int PART_W = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
    localparam int NB_W   = $clog2(PARTITIONS + 1);
    localparam int SLOT_W = $clog2(TASK_SLOTS);
    localparam int HELD_W = 16 + SLOT_W;

    // fit policy codes
    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_NEXT  = 2'd1;
    localparam logic [1:0] POL_BEST  = 2'd2;
    localparam logic [1:0] POL_WORST = 2'd3;

    // result status codes
    localparam logic [1:0] ST_PLACED = 2'd0;
    localparam logic [1:0] ST_NOFIT  = 2'd1;
    localparam logic [1:0] ST_LOADED = 2'd2;

    // partition cell command codes
    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_PLACE = 2'd2;
    localparam logic [1:0] OP_GIVE  = 2'd3;

    // function codes
    localparam logic FN_LOAD  = 1'b0;
    localparam logic FN_PLACE = 1'b1;

    // configuration register indexes
    localparam logic CFG_POLICY = 1'b0;
    localparam logic CFG_BLOCKS = 1'b1;

    typedef struct packed {
        logic        func;
        logic [2:0]  block_index;
        logic [15:0] capacity;
        logic [15:0] task_size;
        logic [15:0] task_time;
        logic        last_task;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  placed_block;
        logic [15:0] wait_ticks;
        logic        total_valid;
        logic [31:0] total_time;
    } t_out;

    // search token moving down the cell chain
    typedef struct packed {
        logic              vld;
        logic              f_first;
        logic [PART_W-1:0] i_first;
        logic              f_ge;
        logic [PART_W-1:0] i_ge;
        logic              f_best;
        logic [PART_W-1:0] i_best;
        logic [15:0]       v_best;
        logic              fe;
    } t_tok;

    // update command broadcast to all cells
    typedef struct packed {
        logic [1:0]        op;
        logic [PART_W-1:0] part;
        logic [15:0]       val;
    } t_pcmd;

    // one task slot entry
    typedef struct packed {
        logic              used;
        logic [15:0]       rem;
        logic [PART_W-1:0] part;
        logic [15:0]       size;
    } t_slot;

endpackage
`default_nettype wire

// ----- src/fit_policy_partition_allocator_top.sv -----
// top level of the fit-policy partition allocator
`default_nettype none
// Places timed tasks into partitions by first, next, best or worst fit. A
// transaction is taken when start is high and busy is low; exactly one result
// follows, shown for one cycle with o_done, and the receiver cannot stall it.
// After reset the slot table is cleared, which keeps busy high until every
// slot is written. A capacity load is answered without a search. A placement
// that fits at once waits for the token to pass down the chain of partition
// cells. Each tick jump that a waiting task needs adds two sweeps over the
// slot ram, and a last task adds one more sweep to total and release the
// residents. Configuration writes take effect at once and are meant for
// times when the block is idle.
module fit_policy_partition_allocator_top (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire fpa_pkg::t_in  i_cmd,
    output logic               o_done,
    output fpa_pkg::t_out      o_result,
    input  wire logic          i_cfg_we,
    input  wire logic          i_cfg_idx,
    input  wire logic [3:0]    i_cfg_data
);
    import fpa_pkg::*;

    localparam logic [2:0] S_CLR    = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_LAUNCH = 3'd2;
    localparam logic [2:0] S_SEARCH = 3'd3;
    localparam logic [2:0] S_MIN    = 3'd4;
    localparam logic [2:0] S_UPD    = 3'd5;
    localparam logic [2:0] S_TOT    = 3'd6;

    localparam int SLOT_BITS = $bits(t_slot);

    logic [2:0]        r_state, n_state;
    logic [1:0]        r_policy;
    logic [3:0]        r_blocks;
    t_in               r_in, n_in;
    logic [PART_W-1:0] r_rotor, n_rotor;
    logic [SLOT_W-1:0] r_counter, n_counter;
    logic [31:0]       r_tick, n_tick;
    logic [15:0]       r_wait, n_wait;
    logic [16:0]       r_k, n_k;
    logic [31:0]       r_sum, n_sum;
    logic              r_first, n_first;
    logic [SLOT_W:0]   r_used_cnt, n_used_cnt;
    logic [SLOT_W:0]   r_sw_addr, n_sw_addr;
    logic              r_sw_vld, n_sw_vld;
    logic [SLOT_W-1:0] r_sw_dad, n_sw_dad;
    logic              r_done, n_done;
    t_out              r_res, n_res;

    // search width and normalized rotor
    logic [7:0]        blk_eff;
    logic [NB_W-1:0]   nb;
    logic [PART_W-1:0] rnorm;

    assign blk_eff = (r_blocks == 4'd0) ? 8'd1 : 8'(r_blocks);
    assign nb      = (blk_eff > 8'(PARTITIONS)) ? NB_W'(PARTITIONS) : NB_W'(blk_eff);
    assign rnorm   = (NB_W'(r_rotor) < nb) ? r_rotor : '0;

    // cell chain
    t_tok   tok [PARTITIONS+1];
    t_tok   tok_inj;
    t_pcmd  pcmd;

    assign tok[0] = tok_inj;

    for (genvar g = 0; g < PARTITIONS; g++) begin : g_cell
        fpa_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_index  (PART_W'(g)),
            .i_nb     (nb),
            .i_rnorm  (rnorm),
            .i_policy (r_policy),
            .i_size   (r_in.task_size),
            .i_tok    (tok[g]),
            .o_tok    (tok[g+1]),
            .i_cmd    (pcmd)
        );
    end

    t_tok              tok_out;
    logic              found;
    logic [PART_W-1:0] found_idx;

    assign tok_out = tok[PARTITIONS];

    // decode the search result for the active policy
    always_comb begin
        case (r_policy)
            POL_FIRST: begin
                found     = tok_out.f_first;
                found_idx = tok_out.i_first;
            end
            POL_NEXT: begin
                found     = tok_out.f_ge | tok_out.f_first;
                found_idx = tok_out.f_ge ? tok_out.i_ge : tok_out.i_first;
            end
            default: begin
                found     = tok_out.f_best;
                found_idx = tok_out.i_best;
            end
        endcase
    end

    // slot table
    logic              ram_we, ram_re;
    logic [SLOT_W-1:0] ram_waddr, ram_raddr;
    t_slot             ram_wdata;
    logic [SLOT_BITS-1:0] ram_rbits;
    t_slot             rd;

    assign rd = t_slot'(ram_rbits);

    fpa_ram #(
        .WIDTH (SLOT_BITS),
        .DEPTH (TASK_SLOTS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rbits)
    );

    logic        accept;
    logic        sw_issue;
    logic        sw_end;
    logic [32:0] tick_sum;
    logic [16:0] wait_sum;
    logic [32:0] tot_sum;

    assign accept   = start && !busy;
    assign sw_issue = r_sw_addr < (SLOT_W + 1)'(TASK_SLOTS);
    assign sw_end   = !sw_issue && !r_sw_vld;
    assign tick_sum = 33'(r_tick) + 33'(r_k);
    assign wait_sum = 17'(r_wait) + r_k;
    assign tot_sum  = 33'(r_sum) + 33'(rd.rem);

    // control sequencer
    always_comb begin
        n_state    = r_state;
        n_in       = r_in;
        n_rotor    = r_rotor;
        n_counter  = r_counter;
        n_tick     = r_tick;
        n_wait     = r_wait;
        n_k        = r_k;
        n_sum      = r_sum;
        n_first    = r_first;
        n_used_cnt = r_used_cnt;
        n_sw_addr  = r_sw_addr;
        n_sw_vld   = 1'b0;
        n_sw_dad   = r_sw_dad;
        n_done     = 1'b0;
        n_res      = r_res;
        tok_inj    = '0;
        pcmd       = '0;
        ram_we     = 1'b0;
        ram_waddr  = r_sw_dad;
        ram_wdata  = '0;
        ram_re     = 1'b0;
        ram_raddr  = r_sw_addr[SLOT_W-1:0];

        // shared sweep read issue
        if (r_state == S_MIN || r_state == S_UPD || r_state == S_TOT) begin
            ram_re = sw_issue;
            if (sw_issue) begin
                n_sw_addr = r_sw_addr + 1'b1;
                n_sw_vld  = 1'b1;
                n_sw_dad  = r_sw_addr[SLOT_W-1:0];
            end
        end

        case (r_state)
            S_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = r_sw_addr[SLOT_W-1:0];
                n_sw_addr = r_sw_addr + 1'b1;
                if (r_sw_addr == (SLOT_W + 1)'(TASK_SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_in    = i_cmd;
                    n_res   = '0;
                    n_wait  = '0;
                    n_first = 1'b1;
                    if (i_cmd.func == FN_LOAD) begin
                        if (8'(i_cmd.block_index) < 8'(PARTITIONS)) begin
                            pcmd.op   = OP_LOAD;
                            pcmd.part = PART_W'(i_cmd.block_index);
                            pcmd.val  = i_cmd.capacity;
                        end
                        n_res.status = ST_LOADED;
                        n_done       = 1'b1;
                    end else begin
                        n_state = S_LAUNCH;
                    end
                end
            end
            S_LAUNCH: begin
                ram_re      = 1'b1;
                ram_raddr   = r_counter;
                tok_inj.vld = 1'b1;
                n_state     = S_SEARCH;
            end
            S_SEARCH: begin
                if (tok_out.vld) begin
                    n_first = 1'b0;
                    if (r_first && !tok_out.fe) begin
                        n_res.status = ST_NOFIT;
                        if (r_in.last_task) begin
                            n_state = S_TOT;
                        end else begin
                            n_state = S_IDLE;
                            n_done  = 1'b1;
                        end
                    end else if (!rd.used && found) begin
                        ram_we         = 1'b1;
                        ram_waddr      = r_counter;
                        ram_wdata.used = 1'b1;
                        ram_wdata.rem  = r_in.task_time;
                        ram_wdata.part = found_idx;
                        ram_wdata.size = r_in.task_size;
                        pcmd.op        = OP_PLACE;
                        pcmd.part      = found_idx;
                        pcmd.val       = r_in.task_size;
                        n_used_cnt     = r_used_cnt + 1'b1;
                        n_counter      = r_counter + 1'b1;
                        if (r_policy == POL_NEXT) begin
                            n_rotor = found_idx;
                        end
                        n_res.status       = ST_PLACED;
                        n_res.placed_block = 3'(found_idx);
                        n_res.wait_ticks   = r_wait;
                        if (r_in.last_task) begin
                            n_state = S_TOT;
                        end else begin
                            n_state = S_IDLE;
                            n_done  = 1'b1;
                        end
                    end else begin
                        if (!rd.used && r_policy == POL_NEXT) begin
                            n_rotor = rnorm;
                        end
                        if (r_used_cnt == '0) begin
                            n_res.status = ST_NOFIT;
                            if (r_in.last_task) begin
                                n_state = S_TOT;
                            end else begin
                                n_state = S_IDLE;
                                n_done  = 1'b1;
                            end
                        end else begin
                            n_state = S_MIN;
                            n_k     = 17'h10000;
                        end
                    end
                    n_sw_addr = '0;
                    n_sum     = r_tick;
                end
            end
            S_MIN: begin
                // smallest remaining time among residents, zero counting as one
                if (r_sw_vld && rd.used) begin
                    if (((rd.rem == 16'd0) ? 17'd1 : 17'(rd.rem)) < r_k) begin
                        n_k = (rd.rem == 16'd0) ? 17'd1 : 17'(rd.rem);
                    end
                end
                if (sw_end) begin
                    n_state   = S_UPD;
                    n_sw_addr = '0;
                end
            end
            S_UPD: begin
                // age residents and release those that expire
                if (r_sw_vld && rd.used) begin
                    ram_we = 1'b1;
                    if (17'(rd.rem) <= r_k) begin
                        ram_wdata  = '0;
                        pcmd.op    = OP_GIVE;
                        pcmd.part  = rd.part;
                        pcmd.val   = rd.size;
                        n_used_cnt = r_used_cnt - 1'b1;
                    end else begin
                        ram_wdata     = rd;
                        ram_wdata.rem = rd.rem - r_k[15:0];
                    end
                end
                if (sw_end) begin
                    n_tick  = tick_sum[32] ? 32'hFFFF_FFFF : tick_sum[31:0];
                    n_wait  = wait_sum[16] ? 16'hFFFF : wait_sum[15:0];
                    n_state = S_LAUNCH;
                end
            end
            S_TOT: begin
                // stream total and release of all residents
                if (r_sw_vld && rd.used) begin
                    n_sum      = tot_sum[32] ? 32'hFFFF_FFFF : tot_sum[31:0];
                    ram_we     = 1'b1;
                    ram_wdata  = '0;
                    pcmd.op    = OP_GIVE;
                    pcmd.part  = rd.part;
                    pcmd.val   = rd.size;
                    n_used_cnt = r_used_cnt - 1'b1;
                end
                if (sw_end) begin
                    n_res.total_valid = 1'b1;
                    n_res.total_time  = r_sum;
                    n_tick    = '0;
                    n_counter = '0;
                    n_rotor   = '0;
                    n_state   = S_IDLE;
                    n_done    = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_rotor    <= '0;
            r_counter  <= '0;
            r_tick     <= '0;
            r_used_cnt <= '0;
            r_sw_addr  <= '0;
            r_sw_vld   <= 1'b0;
            r_done     <= 1'b0;
            r_first    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rotor    <= n_rotor;
            r_counter  <= n_counter;
            r_tick     <= n_tick;
            r_used_cnt <= n_used_cnt;
            r_sw_addr  <= n_sw_addr;
            r_sw_vld   <= n_sw_vld;
            r_done     <= n_done;
            r_first    <= n_first;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_in     <= n_in;
        r_wait   <= n_wait;
        r_k      <= n_k;
        r_sum    <= n_sum;
        r_sw_dad <= n_sw_dad;
        r_res    <= n_res;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= POL_FIRST;
            r_blocks <= 4'd8;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_POLICY: r_policy <= i_cfg_data[1:0];
                CFG_BLOCKS: r_blocks <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

    // a result only follows work in progress or a transaction just taken
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy || start))
        else $error("result without a transaction in progress");

    // resident count stays within the slot table
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used_cnt <= (SLOT_W + 1)'(TASK_SLOTS))
        else $error("resident count out of range");

    // a capacity load never reports a stream total
    a_load_no_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == ST_LOADED) |-> !o_result.total_valid)
        else $error("total reported on a capacity load");

    // a stream total leaves no resident behind
    a_close_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.total_valid) |-> (r_used_cnt == '0))
        else $error("residents left after stream close");
endmodule
`default_nettype wire

// ----- src/fpa_ram.sv -----
// generic simple dual-port ram with registered read
`default_nettype none
module fpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ----- src/fpa_cell.sv -----
// one partition cell: holds free and resident space, evaluates the passing search token
`default_nettype none
module fpa_cell (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic [fpa_pkg::PART_W-1:0] i_index,
    input  wire logic [fpa_pkg::NB_W-1:0]  i_nb,
    input  wire logic [fpa_pkg::PART_W-1:0] i_rnorm,
    input  wire logic [1:0]                i_policy,
    input  wire logic [15:0]               i_size,
    input  wire fpa_pkg::t_tok             i_tok,
    output fpa_pkg::t_tok                  o_tok,
    input  wire fpa_pkg::t_pcmd            i_cmd
);
    import fpa_pkg::*;

    logic [15:0]     r_free;
    logic [HELD_W-1:0] r_held;
    t_tok            r_tok;
    t_tok            n_tok;
    logic            fit;
    logic            fit_empty;
    logic            active;
    logic [16:0]     sat_sum;

    assign fit       = i_size <= r_free;
    assign fit_empty = (HELD_W + 1)'(i_size) <= ((HELD_W + 1)'(r_free) + (HELD_W + 1)'(r_held));
    assign active    = i_tok.vld && (NB_W'(i_index) < i_nb);
    assign sat_sum   = 17'(r_free) + 17'(i_cmd.val);

    // token evaluation
    always_comb begin
        n_tok = i_tok;
        if (active) begin
            if (fit && !i_tok.f_first) begin
                n_tok.f_first = 1'b1;
                n_tok.i_first = i_index;
            end
            if (fit && !i_tok.f_ge && (i_index >= i_rnorm)) begin
                n_tok.f_ge = 1'b1;
                n_tok.i_ge = i_index;
            end
            if (fit) begin
                if (!i_tok.f_best
                    || (i_policy == POL_BEST && r_free < i_tok.v_best)
                    || (i_policy == POL_WORST && r_free > i_tok.v_best)) begin
                    n_tok.f_best = 1'b1;
                    n_tok.i_best = i_index;
                    n_tok.v_best = r_free;
                end
            end
            if (fit_empty) begin
                n_tok.fe = 1'b1;
            end
        end
    end

    // hand the token to the neighbor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    // space bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free <= '0;
            r_held <= '0;
        end else if (i_cmd.part == i_index) begin
            case (i_cmd.op)
                OP_LOAD: begin
                    r_free <= i_cmd.val;
                end
                OP_PLACE: begin
                    r_free <= r_free - i_cmd.val;
                    r_held <= r_held + HELD_W'(i_cmd.val);
                end
                OP_GIVE: begin
                    r_free <= sat_sum[16] ? 16'hFFFF : sat_sum[15:0];
                    r_held <= r_held - HELD_W'(i_cmd.val);
                end
                default: begin
                end
            endcase
        end
    end

    assign o_tok = r_tok;
endmodule
`default_nettype wire

// ----- verif/fpa_checker.sv -----
// checker for the fit-policy partition allocator: predicts results and compares them
`timescale 1ns / 1ps
module fpa_checker (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire logic          busy,
    input  wire fpa_pkg::t_in  i_cmd,
    input  wire logic          o_done,
    input  wire fpa_pkg::t_out o_result,
    input  wire logic          i_cfg_we,
    input  wire logic          i_cfg_idx,
    input  wire logic [3:0]    i_cfg_data,
    output int                 o_errors,
    output int                 o_checked
);
    import fpa_pkg::*;

    // predicted block state
    logic [1:0]        policy_q;
    logic [3:0]        blocks_q;
    logic [15:0]       free_room [PARTITIONS];
    bit                slot_busy [TASK_SLOTS];
    logic [15:0]       slot_left [TASK_SLOTS];
    logic [PART_W-1:0] slot_part [TASK_SLOTS];
    logic [15:0]       slot_bytes [TASK_SLOTS];
    int unsigned       rotor_q;
    int unsigned       task_no;
    longint unsigned   ticks_sum;

    t_out expected_results[$];

    // release one resident task back to its partition
    function automatic void release_slot(int s);
        int unsigned sum;
        slot_busy[s] = 0;
        sum = free_room[slot_part[s]] + slot_bytes[s];
        free_room[slot_part[s]] = (sum > 16'hFFFF) ? 16'hFFFF : sum[15:0];
    endfunction

    // pick a partition under the current policy, -1 when none fits
    function automatic int choose_partition(int unsigned size, int unsigned nb);
        int best;
        int unsigned r;
        best = -1;
        if (policy_q == POL_NEXT) begin
            r = (rotor_q < nb) ? rotor_q : 0;
            for (int p = 0; p < nb; p++) begin
                if (size <= free_room[r]) begin
                    rotor_q = r;
                    return int'(r);
                end
                r = (r + 1) % nb;
            end
            rotor_q = r;
            return -1;
        end
        for (int p = 0; p < nb; p++) begin
            if (size > free_room[p]) continue;
            if (policy_q == POL_FIRST) return p;
            if (best < 0) best = p;
            else if (policy_q == POL_BEST && free_room[p] < free_room[best]) best = p;
            else if (policy_q == POL_WORST && free_room[p] > free_room[best]) best = p;
        end
        return best;
    endfunction

    // would the task fit once every resident has left
    function automatic bit fits_when_drained(int unsigned size, int unsigned nb);
        int unsigned room [PARTITIONS];
        for (int p = 0; p < PARTITIONS; p++) room[p] = free_room[p];
        for (int s = 0; s < TASK_SLOTS; s++)
            if (slot_busy[s]) room[slot_part[s]] += slot_bytes[s];
        for (int p = 0; p < nb; p++)
            if (size <= ((room[p] > 16'hFFFF) ? 16'hFFFF : room[p])) return 1;
        return 0;
    endfunction

    // jump time to the next expiry, 0 when nothing is resident
    function automatic int unsigned advance_to_expiry();
        int unsigned k;
        int unsigned r;
        bit any;
        k = 32'h10000;
        any = 0;
        for (int s = 0; s < TASK_SLOTS; s++) begin
            if (slot_busy[s]) begin
                r = (slot_left[s] == 0) ? 1 : slot_left[s];
                if (r < k) k = r;
                any = 1;
            end
        end
        if (!any) return 0;
        for (int s = 0; s < TASK_SLOTS; s++) begin
            if (!slot_busy[s]) continue;
            if (slot_left[s] <= k) release_slot(s);
            else slot_left[s] = slot_left[s] - k[15:0];
        end
        return k;
    endfunction

    // result of one accepted command
    function automatic t_out allocate(t_in c);
        t_out r;
        int unsigned nb;
        int unsigned slot;
        int unsigned k;
        longint unsigned waited;
        longint unsigned tot;
        int blk;
        r = '0;
        waited = 0;
        blk = -1;
        nb = (blocks_q == 0) ? 1 : ((blocks_q > PARTITIONS) ? PARTITIONS : blocks_q);
        slot = task_no % TASK_SLOTS;
        if (c.func == FN_LOAD) begin
            free_room[c.block_index] = c.capacity;
            r.status = ST_LOADED;
            return r;
        end
        if (fits_when_drained(c.task_size, nb)) begin
            forever begin
                if (!slot_busy[slot]) begin
                    blk = choose_partition(c.task_size, nb);
                    if (blk >= 0) break;
                end
                k = advance_to_expiry();
                if (k == 0) break;
                waited += k;
                ticks_sum += k;
                if (ticks_sum > 64'hFFFF_FFFF) ticks_sum = 64'hFFFF_FFFF;
            end
        end
        if (blk >= 0) begin
            slot_busy[slot] = 1;
            slot_left[slot] = c.task_time;
            slot_part[slot] = blk[PART_W-1:0];
            slot_bytes[slot] = c.task_size;
            free_room[blk] = free_room[blk] - c.task_size;
            task_no = (task_no + 1) % TASK_SLOTS;
            r.status = ST_PLACED;
            r.placed_block = blk[2:0];
            r.wait_ticks = (waited > 16'hFFFF) ? 16'hFFFF : waited[15:0];
        end else begin
            r.status = ST_NOFIT;
        end
        if (c.last_task) begin
            tot = ticks_sum;
            for (int s = 0; s < TASK_SLOTS; s++)
                if (slot_busy[s]) tot += slot_left[s];
            r.total_valid = 1'b1;
            r.total_time = (tot > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : tot[31:0];
            for (int s = 0; s < TASK_SLOTS; s++)
                if (slot_busy[s]) release_slot(s);
            ticks_sum = 0;
            task_no = 0;
            rotor_q = 0;
        end
        return r;
    endfunction

    function automatic void report(string field, longint unsigned e, longint unsigned a);
        if (e != a) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, e, a);
            o_errors++;
        end
    endfunction

    initial begin
        o_errors = 0;
        o_checked = 0;
    end

    // watch config, command and result channels
    always @(posedge i_clk) begin
        t_out exp_r;
        if (!i_rst_n) begin
            policy_q = POL_FIRST;
            blocks_q = 4'd8;
            for (int p = 0; p < PARTITIONS; p++) free_room[p] = '0;
            for (int s = 0; s < TASK_SLOTS; s++) begin
                slot_busy[s] = 0;
                slot_left[s] = '0;
                slot_part[s] = '0;
                slot_bytes[s] = '0;
            end
            rotor_q = 0;
            task_no = 0;
            ticks_sum = 0;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_POLICY) policy_q = i_cfg_data[1:0];
                else blocks_q = i_cfg_data;
            end
            // compare before queuing so a same-edge transaction is not matched
            if (o_done) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result with nothing expected, actual %p", $time, o_result);
                    o_errors++;
                end else begin
                    exp_r = expected_results.pop_front();
                    report("status", exp_r.status, o_result.status);
                    report("placed_block", exp_r.placed_block, o_result.placed_block);
                    report("wait_ticks", exp_r.wait_ticks, o_result.wait_ticks);
                    report("total_valid", exp_r.total_valid, o_result.total_valid);
                    report("total_time", exp_r.total_time, o_result.total_time);
                end
                o_checked++;
            end
            if (start && !busy) expected_results.push_back(allocate(i_cmd));
        end
    end

endmodule

// ----- verif/fit_policy_partition_allocator_top_test.sv -----
// testbench top: stimulus, idling and verdict for the fit-policy partition allocator
`timescale 1ns / 1ps
module fit_policy_partition_allocator_top_test;
    import fpa_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_in         i_cmd;
    logic        o_done;
    t_out        o_result;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [3:0]  i_cfg_data;
    int          errors;
    int          checked;
    int          sent;
    int          done_cnt;
    int          gap_pct;
    int          streams;

    fit_policy_partition_allocator_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cmd      (i_cmd),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    fpa_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cmd      (i_cmd),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_errors   (errors),
        .o_checked  (checked)
    );

    // 4 ns clock
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // count results seen
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) done_cnt <= done_cnt + 1;
    end

    // one command transaction, then an optional gap
    task automatic issue(input t_in c);
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
        sent++;
        if ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic load_part(input int idx, input int cap, input bit last);
        t_in c;
        c = '0;
        c.func = FN_LOAD;
        c.block_index = idx[2:0];
        c.capacity = cap[15:0];
        c.task_size = $urandom;
        c.task_time = $urandom;
        c.last_task = last;
        issue(c);
    endtask

    task automatic place_task(input int size, input int ticks, input bit last);
        t_in c;
        c = '0;
        c.func = FN_PLACE;
        c.block_index = $urandom;
        c.capacity = $urandom;
        c.task_size = size[15:0];
        c.task_time = ticks[15:0];
        c.last_task = last;
        issue(c);
    endtask

    // register write once every result is in and the block is idle
    task automatic write_reg(input logic idx, input int val);
        start <= 1'b0;
        do @(posedge i_clk); while (done_cnt != sent || busy);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val[3:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // generous run limit
    initial begin
        #400_000_000;
        $display("fit_policy_partition_allocator_top_test NOT OK");
        $finish;
    end

    initial begin
        int sz;
        int tm;
        int ntask;
        int cap;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cmd = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_POLICY;
        i_cfg_data = '0;
        sent = 0;
        done_cnt = 0;
        gap_pct = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: first fit, extremes of sizes and times
        write_reg(CFG_POLICY, POL_FIRST);
        write_reg(CFG_BLOCKS, 8);
        load_part(0, 65535, 1'b1);
        load_part(1, 0, 1'b0);
        load_part(2, 100, 1'b0);
        load_part(3, 300, 1'b0);
        load_part(7, 200, 1'b0);
        place_task(65535, 0, 1'b0);
        place_task(0, 65535, 1'b0);
        place_task(65535, 5, 1'b0);
        place_task(150, 65535, 1'b1);
        // best fit with a task too large for the searched partitions
        write_reg(CFG_POLICY, POL_BEST);
        write_reg(CFG_BLOCKS, 3);
        load_part(0, 50, 1'b0);
        place_task(60000, 3, 1'b0);
        place_task(40, 7, 1'b0);
        place_task(90, 2, 1'b1);
        // worst fit, search width of zero counts as one
        write_reg(CFG_POLICY, POL_WORST);
        place_task(30, 4, 1'b0);
        write_reg(CFG_BLOCKS, 0);
        place_task(50, 9, 1'b0);
        place_task(60000, 1, 1'b1);
        // next fit with the rotor wrapping, width above the partition count
        write_reg(CFG_POLICY, POL_NEXT);
        write_reg(CFG_BLOCKS, 15);
        place_task(200, 65535, 1'b0);
        place_task(200, 1000, 1'b0);
        place_task(200, 10, 1'b0);
        place_task(65535, 20, 1'b1);

        // random streams of tasks, idling changing by phase
        streams = 0;
        while (sent < 900) begin
            case (streams % 4)
                0: gap_pct = 0;
                1: gap_pct = 45;
                2: gap_pct = 0;
                default: gap_pct = 8;
            endcase
            if ($urandom_range(2) == 0) write_reg(CFG_POLICY, $urandom_range(3));
            if ($urandom_range(2) == 0)
                write_reg(CFG_BLOCKS, ($urandom_range(4) == 0) ? $urandom_range(15)
                                                               : $urandom_range(3, 8));
            for (int p = 0; p < PARTITIONS; p++) begin
                if ($urandom_range(1) == 0) begin
                    cap = ($urandom_range(9) == 0) ? $urandom : $urandom_range(200, 4000);
                    load_part(p, cap, $urandom_range(1));
                end
            end
            ntask = $urandom_range(3, 12);
            for (int t = 0; t < ntask; t++) begin
                if ($urandom_range(99) < 8)
                    load_part($urandom_range(7), $urandom_range(0, 65535), $urandom_range(1));
                case ($urandom_range(19))
                    0: sz = $urandom_range(0, 65535);
                    1: sz = 0;
                    default: sz = $urandom_range(1, 1500);
                endcase
                tm = ($urandom_range(9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 40);
                place_task(sz, tm, t == ntask - 1);
            end
            streams++;
        end

        // drain and settle
        start <= 1'b0;
        do @(posedge i_clk); while (done_cnt != sent);
        repeat (50) @(posedge i_clk);
        $display("covered %0d transactions over %0d random task streams, %0d results checked",
                 sent, streams, checked);
        $display("all four fit policies, search widths 0 to 15, waits and stream totals");
        if (errors == 0 && done_cnt == sent) begin
            $display("fit_policy_partition_allocator_top_test OK");
        end else begin
            $display("fit_policy_partition_allocator_top_test NOT OK");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/fpa_pkg.sv
src/fpa_ram.sv
src/fpa_cell.sv
src/fit_policy_partition_allocator_top.sv
verif/fpa_checker.sv
verif/fit_policy_partition_allocator_top_test.sv
